// File: rtl/rsch_pkg.sv
// types and constants shared by the ray segment closest-hit block
// no dependencies
package rsch_pkg;

  localparam int unsigned DIST_W  = 31;
  localparam int unsigned WALL_W  = 8;
  localparam int unsigned NUMT_W  = 67;
  localparam int unsigned DEN_W   = 50;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);

  localparam logic [DIST_W-1:0] DistMax      = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] DistReset    = 31'd83886080;
  localparam logic [DIST_W-1:0] MinHitDist   = 31'd655;
  localparam logic signed [DEN_W-1:0] ParallelEps = 50'sd107374;

  // classified wall handed from the front to the back
  typedef struct packed {
    logic [NUMT_W-1:0] num_t;
    logic [DEN_W-1:0]  denom;
    logic              cand;
    logic              side;
    logic              first;
    logic              last;
  } wall_entry_t;

endpackage

// File: rtl/rsch_front.sv
// front end: accepts a wall, forms cross products and classifies it
// depends on rsch_pkg
module rsch_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   origin_x_i,
  input  logic signed [31:0]   origin_y_i,
  input  logic signed [15:0]   dir_x_i,
  input  logic signed [15:0]   dir_y_i,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [15:0]   normal_x_i,
  input  logic signed [15:0]   normal_y_i,
  input  logic                 first_wall_i,
  input  logic                 last_wall_i,
  output logic                 push_o,
  input  logic                 full_i,
  output rsch_pkg::wall_entry_t entry_o
);
  import rsch_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_CLS  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;

  logic signed [32:0] wx_q, wy_q, fx_q, fy_q;
  logic signed [15:0] dx_q, dy_q, nx_q, ny_q;
  logic               first_q, last_q;
  logic signed [48:0] p_dwy_q, p_dywx_q, p_fxdy_q, p_fydx_q;
  logic signed [65:0] p_fxwy_q, p_fywx_q;
  logic signed [32:0] dot_q;
  wall_entry_t        entry_q;

  logic signed [DEN_W-1:0]  den, den_abs, ns, ns_n;
  logic signed [NUMT_W-1:0] nt, nt_n;
  logic                     neg, par;

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign entry_o    = entry_q;

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_MUL;
      F_MUL:  state_d = F_CLS;
      F_CLS:  state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sign normalization and hit tests
  always_comb begin
    den     = DEN_W'(p_dwy_q) - DEN_W'(p_dywx_q);
    nt      = NUMT_W'(p_fxwy_q) - NUMT_W'(p_fywx_q);
    ns      = DEN_W'(p_fxdy_q) - DEN_W'(p_fydx_q);
    neg     = den[DEN_W-1];
    par     = (den > -ParallelEps) && (den < ParallelEps);
    den_abs = neg ? -den : den;
    nt_n    = neg ? -nt : nt;
    ns_n    = neg ? -ns : ns;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      wx_q    <= 33'(end_x_i) - 33'(start_x_i);
      wy_q    <= 33'(end_y_i) - 33'(start_y_i);
      fx_q    <= 33'(start_x_i) - 33'(origin_x_i);
      fy_q    <= 33'(start_y_i) - 33'(origin_y_i);
      dx_q    <= dir_x_i;
      dy_q    <= dir_y_i;
      nx_q    <= normal_x_i;
      ny_q    <= normal_y_i;
      first_q <= first_wall_i;
      last_q  <= last_wall_i;
    end
    if (state_q == F_MUL) begin
      p_dwy_q  <= dx_q * wy_q;
      p_dywx_q <= dy_q * wx_q;
      p_fxdy_q <= fx_q * dy_q;
      p_fydx_q <= fy_q * dx_q;
      p_fxwy_q <= fx_q * wy_q;
      p_fywx_q <= fy_q * wx_q;
      dot_q    <= 33'(dx_q * nx_q) + 33'(dy_q * ny_q);
    end
    if (state_q == F_CLS) begin
      entry_q.num_t <= nt_n;
      entry_q.denom <= den_abs;
      entry_q.cand  <= !par && !nt_n[NUMT_W-1] && (nt_n != '0) &&
                       !ns_n[DEN_W-1] && (ns_n <= den_abs);
      entry_q.side  <= (dot_q > 33'sd0);
      entry_q.first <= first_q;
      entry_q.last  <= last_q;
    end
  end

endmodule

// File: rtl/rsch_fifo.sv
// short queue between the front and the back
// depends on rsch_pkg
module rsch_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rsch_pkg::wall_entry_t data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output rsch_pkg::wall_entry_t data_o
);
  import rsch_pkg::*;

  wall_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_q, rd_q;
  logic [QPTR_W:0]      cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: rtl/rsch_back.sv
// back end: divides for the ray parameter, keeps the nearest hit, emits result
// depends on rsch_pkg
module rsch_back #(
  parameter int unsigned MAX_WALLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [rsch_pkg::DIST_W-1:0] max_dist_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  rsch_pkg::wall_entry_t entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic [rsch_pkg::DIST_W-1:0] hit_distance_o,
  output logic [rsch_pkg::WALL_W-1:0] hit_wall_o,
  output logic                  back_side_o
);
  import rsch_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_UPD  = 3'b100
  } back_state_e;

  back_state_e state_q;
  wall_entry_t ent_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DIST_W-1:0] lo_q, t_q;
  logic [4:0]        step_q;

  logic [DIST_W-1:0] best_q;
  logic [WALL_W-1:0] wall_q, cnt_q;
  logic              side_q, any_q;

  logic              out_valid_q, out_hit_q, out_side_q;
  logic              out_valid_d;
  logic [DIST_W-1:0] out_dist_q;
  logic [WALL_W-1:0] out_wall_q;

  logic [DEN_W:0]    r2;
  logic              qbit;
  logic              sat;
  logic [DIST_W-1:0] base_best, new_best;
  logic [WALL_W-1:0] base_cnt, new_wall;
  logic              base_side, base_any, new_side, new_any, win;
  logic [WALL_W:0]   nxt;
  logic [WALL_W-1:0] cnt_next;
  logic              out_free, upd_go;

  assign pop_o          = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign hit_distance_o = out_dist_q;
  assign hit_wall_o     = out_wall_q;
  assign back_side_o    = out_side_q;

  // one restoring division step, and the check for a quotient too large to fit
  always_comb begin
    r2   = {rem_q, lo_q[DIST_W-1]};
    qbit = (r2 >= {1'b0, ent_q.denom});
    sat  = (entry_i.num_t >= (NUMT_W'(entry_i.denom) << 17));
  end

  // nearest-hit update
  always_comb begin
    base_best = ent_q.first ? max_dist_i : best_q;
    base_cnt  = ent_q.first ? '0 : cnt_q;
    base_side = ent_q.first ? 1'b0 : side_q;
    base_any  = ent_q.first ? 1'b0 : any_q;
    new_best  = base_best;
    new_wall  = ent_q.first ? '0 : wall_q;
    new_side  = base_side;
    new_any   = base_any;
    win       = (t_q > MinHitDist) && (t_q < base_best);
    if (win) begin
      new_best = t_q;
      new_wall = base_cnt;
      new_side = ent_q.side;
      new_any  = 1'b1;
    end
    nxt      = {1'b0, base_cnt} + 1'b1;
    cnt_next = ((32'(nxt) >= MAX_WALLS) || nxt[WALL_W]) ? '0 : nxt[WALL_W-1:0];
    out_free = !out_valid_q || out_ready_i;
    upd_go   = (state_q == B_UPD) && (!ent_q.last || out_free);
    // result valid: cleared when taken, set when a ray finishes
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (upd_go && ent_q.last) out_valid_d = 1'b1;
  end

  // control and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      best_q      <= DistReset;
      wall_q      <= '0;
      cnt_q       <= '0;
      side_q      <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            step_q  <= '0;
            state_q <= (entry_i.cand && !sat) ? B_DIV : B_UPD;
          end
        end
        B_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == 5'(DIST_W - 1)) state_q <= B_UPD;
        end
        B_UPD: begin
          if (upd_go) begin
            state_q <= B_IDLE;
            if (ent_q.last) begin
              best_q      <= max_dist_i;
              wall_q      <= '0;
              cnt_q       <= '0;
              side_q      <= 1'b0;
              any_q       <= 1'b0;
            end else begin
              best_q <= new_best;
              wall_q <= new_wall;
              cnt_q  <= cnt_next;
              side_q <= new_side;
              any_q  <= new_any;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // divider datapath and result register
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !empty_i) begin
      ent_q <= entry_i;
      rem_q <= entry_i.num_t[NUMT_W-1:17];
      lo_q  <= {entry_i.num_t[16:0], 14'b0};
      t_q   <= DistMax;
      if (entry_i.cand && !sat) t_q <= '0;
    end
    if (state_q == B_DIV) begin
      rem_q <= qbit ? DEN_W'(r2 - {1'b0, ent_q.denom}) : r2[DEN_W-1:0];
      lo_q  <= lo_q << 1;
      t_q   <= {t_q[DIST_W-2:0], qbit};
    end
    if (upd_go && ent_q.last) begin
      out_hit_q  <= new_any;
      out_dist_q <= new_best;
      out_wall_q <= new_wall;
      out_side_q <= new_side;
    end
  end

endmodule

// File: rtl/ray_segment_closest_hit.sv
// top level of the ray segment closest-hit block: stream ports and register port
// depends on rsch_pkg, rsch_front, rsch_fifo, rsch_back
//
// Takes one ray/wall pair per input word and reports, on the word marked tlast,
// the nearest wall hit of that ray (hit flag in m_axis_tuser, distance, wall
// position and side in m_axis_tdata). A word passes through the front
// (subtract, multiply, classify, queue) and then the back, where a 31-step
// restoring divider forms the hit distance; the last word of a ray waits in
// the update step there while the previous result is still unread. Walls that
// cannot hit skip the divider. The back finishes one wall before it takes the
// next, so the divider sets the sustained rate. The two-entry queue lets the
// front take the next wall while the back divides. max_distance is written at
// byte address 0 and takes effect when the next ray starts.
module ray_segment_closest_hit #(
  parameter int unsigned MAX_WALLS = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, dir_x, dir_y, start_x, start_y, end_x, end_y,
  // normal_x, normal_y
  input  logic [255:0] s_axis_tdata,
  // first_wall
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_distance, hit_wall, back_side
  output logic [39:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rsch_pkg::*;

  localparam logic [2:0] AddrMaxDist = 3'd0;

  logic [DIST_W-1:0] max_q;
  logic              push, full, pop, empty;
  wall_entry_t       f_entry, b_entry;
  logic [DIST_W-1:0] hit_distance;
  logic [WALL_W-1:0] hit_wall;
  logic              back_side;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxDist) ? {1'b0, max_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= DistReset;
    end else if (psel && penable && pwrite && paddr == AddrMaxDist) begin
      max_q <= pwdata[DIST_W-1:0];
    end
  end

  rsch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .origin_x_i   (s_axis_tdata[31:0]),
    .origin_y_i   (s_axis_tdata[63:32]),
    .dir_x_i      (s_axis_tdata[79:64]),
    .dir_y_i      (s_axis_tdata[95:80]),
    .start_x_i    (s_axis_tdata[127:96]),
    .start_y_i    (s_axis_tdata[159:128]),
    .end_x_i      (s_axis_tdata[191:160]),
    .end_y_i      (s_axis_tdata[223:192]),
    .normal_x_i   (s_axis_tdata[239:224]),
    .normal_y_i   (s_axis_tdata[255:240]),
    .first_wall_i (s_axis_tuser),
    .last_wall_i  (s_axis_tlast),
    .push_o       (push),
    .full_i       (full),
    .entry_o      (f_entry)
  );

  rsch_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (b_entry)
  );

  rsch_back #(
    .MAX_WALLS (MAX_WALLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_dist_i     (max_q),
    .empty_i        (empty),
    .pop_o          (pop),
    .entry_i        (b_entry),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .hit_o          (m_axis_tuser),
    .hit_distance_o (hit_distance),
    .hit_wall_o     (hit_wall),
    .back_side_o    (back_side)
  );

  assign m_axis_tdata = {back_side, hit_wall, hit_distance};

endmodule

// File: rtl/rsch_checker.sv
// port-level checks for the ray segment closest-hit block, bound to the top
// depends on ray_segment_closest_hit
module rsch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no hit reports wall zero on the front side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:31] == 9'd0)
    else $error("miss with nonzero wall or side");

  // a reported hit lies beyond the minimum distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[30:0] > 31'd655)
    else $error("hit closer than minimum distance");

  // register port never waits
  assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind ray_segment_closest_hit rsch_checker u_rsch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
